@@ rtl/core/rkpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkpc_pkg: shared types and constants of the raw key translator
// Holds the result type and the scan code constants used by the core.
// ----------------------------------------------------------------------------
package rkpc_pkg;

	localparam int unsigned KEY_W  = 7;
	localparam int unsigned QUAL_W = 2;
	localparam int unsigned SCAN_W = 8;

	// Qualifier bit positions.
	localparam int unsigned QUAL_PAD  = 0;
	localparam int unsigned QUAL_CTRL = 1;

	// Extended (E0) prefix marker and the "no key" code.
	localparam logic [SCAN_W-1:0] SCAN_EXT  = 8'h80;
	localparam logic [SCAN_W-1:0] SCAN_NONE = 8'h00;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [QUAL_W-1:0] qual_t;
	typedef logic [SCAN_W-1:0] scan_t;

	typedef struct packed {
		scan_t scan_code;
		logic  numlock_write;
		logic  numlock_value;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/core/rkpc_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkpc_if: word channels of the raw key translator
// Valid/ready channels for raw key words in and scan code words out.
// ----------------------------------------------------------------------------
interface rkpc_key_if;
	logic             valid;
	logic             ready;
	rkpc_pkg::key_t   raw_key;
	rkpc_pkg::qual_t  qualifiers;

	modport source (output valid, output raw_key, output qualifiers, input ready);
	modport sink   (input valid, input raw_key, input qualifiers, output ready);
endinterface

interface rkpc_scan_if;
	logic             valid;
	logic             ready;
	rkpc_pkg::scan_t  scan_code;
	logic             numlock_write;
	logic             numlock_value;

	modport source (output valid, output scan_code, output numlock_write,
		output numlock_value, input ready);
	modport sink   (input valid, input scan_code, input numlock_write,
		input numlock_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rkpc_translate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rkpc_translate: raw key code to set-1 scan code lookup
// Applies the keypad undo of the alternate mode and maps the key to a scan code.
// ----------------------------------------------------------------------------
module rkpc_translate (
	input  wire rkpc_pkg::key_t   raw_key,
	input  wire rkpc_pkg::qual_t  qualifiers,
	input  wire logic             alt_mode,
	output rkpc_pkg::result_t     result
);

	logic            pad;
	logic            ctrl;
	logic            undo_hit;
	rkpc_pkg::key_t  undo_key;
	logic            digit_pad;
	rkpc_pkg::key_t  key;
	rkpc_pkg::scan_t key_ext;
	rkpc_pkg::scan_t scan;
	logic            nl_write;
	logic            nl_value;

	assign pad     = qualifiers[rkpc_pkg::QUAL_PAD];
	assign ctrl    = qualifiers[rkpc_pkg::QUAL_CTRL];
	assign key_ext = {1'b0, key};

	always_comb begin
		undo_hit = 1'b1;
		undo_key = raw_key;
		case (raw_key)
			7'h70: undo_key = 7'h3d;
			7'h4c: undo_key = 7'h3e;
			7'h48: undo_key = 7'h3f;
			7'h4f: undo_key = 7'h2d;
			7'h4e: undo_key = 7'h2f;
			7'h71: undo_key = 7'h1d;
			7'h4d: undo_key = 7'h1e;
			7'h49: undo_key = 7'h1f;
			7'h47: undo_key = 7'h0f;
			7'h46: undo_key = 7'h3c;
			default: undo_hit = 1'b0;
		endcase
	end

	always_comb begin
		digit_pad = raw_key inside {7'h3d, 7'h3e, 7'h3f, 7'h2d, 7'h2e, 7'h2f,
			7'h1d, 7'h1e, 7'h1f, 7'h0f, 7'h3c};
	end

	always_comb begin
		key      = raw_key;
		nl_write = 1'b0;
		nl_value = 1'b0;
		if (alt_mode && pad) begin
			if (undo_hit) begin
				key      = undo_key;
				nl_write = 1'b1;
			end else if (digit_pad) begin
				nl_write = 1'b1;
				nl_value = 1'b1;
			end
		end
	end

	always_comb begin
		scan = rkpc_pkg::SCAN_NONE;
		case (key) inside
			[7'h01:7'h0c]: scan = key_ext + 8'd1;
			[7'h10:7'h1b]: scan = key_ext;
			[7'h1d:7'h1f]: scan = key_ext + 8'd50;
			[7'h20:7'h2a]: scan = key_ext - 8'd2;
			[7'h2d:7'h2f]: scan = key_ext + 8'd30;
			[7'h31:7'h3a]: scan = key_ext - 8'd5;
			[7'h3d:7'h3f]: scan = key_ext + 8'd10;
			[7'h50:7'h59]: scan = key_ext - 8'd21;
			7'h00: scan = 8'h29;
			7'h0d: scan = 8'h2b;
			7'h0f: scan = 8'h52;
			7'h2b: scan = 8'h2b;
			7'h30: scan = 8'h56;
			7'h3c: scan = 8'h53;
			7'h40: scan = 8'h39;
			7'h41: scan = 8'h0e;
			7'h42: scan = 8'h0f;
			7'h43: scan = 8'h1c | rkpc_pkg::SCAN_EXT;
			7'h44: scan = 8'h1c;
			7'h45: scan = 8'h01;
			7'h46: scan = 8'h53 | rkpc_pkg::SCAN_EXT;
			7'h47: scan = 8'h52 | rkpc_pkg::SCAN_EXT;
			7'h48: scan = 8'h49 | rkpc_pkg::SCAN_EXT;
			7'h49: scan = 8'h51 | rkpc_pkg::SCAN_EXT;
			7'h4a: scan = 8'h4a;
			7'h4b: scan = 8'h57;
			7'h4c: scan = 8'h48 | rkpc_pkg::SCAN_EXT;
			7'h4d: scan = 8'h50 | rkpc_pkg::SCAN_EXT;
			7'h4e: scan = 8'h4d | rkpc_pkg::SCAN_EXT;
			7'h4f: scan = 8'h4b | rkpc_pkg::SCAN_EXT;
			7'h5a: scan = 8'h45;
			7'h5b: scan = 8'h46;
			7'h5c: scan = 8'h35 | rkpc_pkg::SCAN_EXT;
			7'h5d: scan = ctrl ? (8'h37 | rkpc_pkg::SCAN_EXT) : 8'h37;
			7'h5e: scan = 8'h4e;
			7'h5f: scan = alt_mode ? 8'h46 : (8'h5d | rkpc_pkg::SCAN_EXT);
			7'h60: scan = 8'h2a;
			7'h61: scan = 8'h36;
			7'h62: scan = 8'h3a;
			7'h63: scan = 8'h1d;
			7'h64: scan = 8'h38;
			7'h65: scan = 8'h38 | rkpc_pkg::SCAN_EXT;
			7'h66: scan = 8'h5b | rkpc_pkg::SCAN_EXT;
			7'h67: scan = 8'h5c | rkpc_pkg::SCAN_EXT;
			7'h6b: scan = alt_mode ? (8'h5d | rkpc_pkg::SCAN_EXT) : 8'h46;
			7'h6c: scan = alt_mode ? rkpc_pkg::SCAN_NONE : (8'h37 | rkpc_pkg::SCAN_EXT);
			7'h6d: scan = alt_mode ? (8'h37 | rkpc_pkg::SCAN_EXT) : 8'h45;
			7'h6e: scan = ctrl ? (8'h46 | rkpc_pkg::SCAN_EXT) : rkpc_pkg::SCAN_NONE;
			7'h6f: scan = 8'h58;
			7'h70: scan = 8'h47 | rkpc_pkg::SCAN_EXT;
			7'h71: scan = 8'h4f | rkpc_pkg::SCAN_EXT;
			7'h72: scan = 8'h24 | rkpc_pkg::SCAN_EXT;
			7'h73: scan = 8'h22 | rkpc_pkg::SCAN_EXT;
			7'h74: scan = 8'h10 | rkpc_pkg::SCAN_EXT;
			7'h75: scan = 8'h19 | rkpc_pkg::SCAN_EXT;
			7'h76: scan = 8'h2e | rkpc_pkg::SCAN_EXT;
			7'h77: scan = 8'h30 | rkpc_pkg::SCAN_EXT;
			7'h79: scan = 8'h45;
			default: scan = rkpc_pkg::SCAN_NONE;
		endcase
	end

	assign result = {scan, nl_write, nl_value};

endmodule
`default_nettype wire

@@ rtl/core/raw_key_to_pc_scancode_translator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// raw_key_to_pc_scancode_translator: raw key code to set-1 scan code
// Two-stage translator with a mode register for the alternate key assignment.
// ----------------------------------------------------------------------------
// Each raw key word gives exactly one scan code word. The block takes one
// word per clock cycle while the output is not stalled and hands the result
// out through an input register and a result register; the lookup between
// them is combinational. When the output is stalled the stages fill and ready
// falls only once both registers hold words. The mode register is written with
// mode_we and resets to 0; write it only while no word is in flight.
module raw_key_to_pc_scancode_translator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       mode_we,
	input  wire logic       mode_wdata,
	rkpc_key_if.sink        key_in,
	rkpc_scan_if.source     scan_out
);

	logic               alt_mode_q;
	logic               valid_s1;
	logic               valid_s2;
	rkpc_pkg::key_t     raw_key_s1;
	rkpc_pkg::qual_t    qualifiers_s1;
	rkpc_pkg::result_t  result_comb;
	rkpc_pkg::result_t  result_s2;
	logic               adv_s1;
	logic               adv_s2;

	assign adv_s2       = !valid_s2 || scan_out.ready;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign key_in.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_mode_q <= 1'b0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (mode_we) begin
				alt_mode_q <= mode_wdata;
			end
			if (adv_s1) begin
				valid_s1 <= key_in.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && key_in.valid) begin
			raw_key_s1    <= key_in.raw_key;
			qualifiers_s1 <= key_in.qualifiers;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_comb;
		end
	end

	rkpc_translate u_translate (
		.raw_key    (raw_key_s1),
		.qualifiers (qualifiers_s1),
		.alt_mode   (alt_mode_q),
		.result     (result_comb)
	);

	assign scan_out.valid         = valid_s2;
	assign scan_out.scan_code     = result_s2.scan_code;
	assign scan_out.numlock_write = result_s2.numlock_write;
	assign scan_out.numlock_value = result_s2.numlock_value;

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the raw key to scan code translator
// Drives raw key words through the valid/ready input channel with random
// gaps, stalls the scan code channel at random and checks every scan code
// word against a predictor of the translation. Both settings of the mode
// register are exercised, with directed extremes first and random words after.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned MAX_WAIT     = 17;
	localparam int unsigned RANDOM_WORDS = 850;

	localparam rkpc_pkg::key_t KEY_PAUSE    = 7'h6e;
	localparam rkpc_pkg::key_t KEY_PAD_STAR = 7'h5d;
	localparam rkpc_pkg::key_t KEY_PAD_FIVE = 7'h2e;

	localparam rkpc_pkg::key_t KEYPAD_CODES [21] = '{
		7'h70, 7'h4c, 7'h48, 7'h4f, 7'h4e, 7'h71, 7'h4d, 7'h49, 7'h47, 7'h46,
		7'h3d, 7'h3e, 7'h3f, 7'h2d, 7'h2e, 7'h2f, 7'h1d, 7'h1e, 7'h1f, 7'h0f,
		7'h3c
	};

	logic clk = 1'b0;
	logic arst_n;
	logic mode_we;
	logic mode_wdata;

	bit                 alt_mode = 1'b0;
	bit                 no_idle = 1'b0;
	int                 mismatch_count = 0;
	int unsigned        cycle_count = 0;
	rkpc_pkg::result_t  scan_expected [$];

	rkpc_key_if  key_ch ();
	rkpc_scan_if scan_ch ();

	raw_key_to_pc_scancode_translator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.key_in     (key_ch),
		.scan_out   (scan_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic rkpc_pkg::scan_t key_to_scan(rkpc_pkg::key_t k, logic ctrl,
		logic alt);
		int unsigned v;
		v = k;
		if (v >= 'h01 && v <= 'h0c) return rkpc_pkg::scan_t'(v + 1);
		if (v >= 'h10 && v <= 'h1b) return rkpc_pkg::scan_t'(v);
		if (v >= 'h1d && v <= 'h1f) return rkpc_pkg::scan_t'(v + 50);
		if (v >= 'h20 && v <= 'h2a) return rkpc_pkg::scan_t'(v - 2);
		if (v >= 'h2d && v <= 'h2f) return rkpc_pkg::scan_t'(v + 30);
		if (v >= 'h31 && v <= 'h3a) return rkpc_pkg::scan_t'(v - 5);
		if (v >= 'h3d && v <= 'h3f) return rkpc_pkg::scan_t'(v + 10);
		if (v >= 'h50 && v <= 'h59) return rkpc_pkg::scan_t'(v - 21);
		case (k)
			7'h00: return 8'h29;
			7'h0d: return 8'h2b;
			7'h0f: return 8'h52;
			7'h2b: return 8'h2b;
			7'h30: return 8'h56;
			7'h3c: return 8'h53;
			7'h40: return 8'h39;
			7'h41: return 8'h0e;
			7'h42: return 8'h0f;
			7'h43: return 8'h1c | rkpc_pkg::SCAN_EXT;
			7'h44: return 8'h1c;
			7'h45: return 8'h01;
			7'h46: return 8'h53 | rkpc_pkg::SCAN_EXT;
			7'h47: return 8'h52 | rkpc_pkg::SCAN_EXT;
			7'h48: return 8'h49 | rkpc_pkg::SCAN_EXT;
			7'h49: return 8'h51 | rkpc_pkg::SCAN_EXT;
			7'h4a: return 8'h4a;
			7'h4b: return 8'h57;
			7'h4c: return 8'h48 | rkpc_pkg::SCAN_EXT;
			7'h4d: return 8'h50 | rkpc_pkg::SCAN_EXT;
			7'h4e: return 8'h4d | rkpc_pkg::SCAN_EXT;
			7'h4f: return 8'h4b | rkpc_pkg::SCAN_EXT;
			7'h5a: return 8'h45;
			7'h5b: return 8'h46;
			7'h5c: return 8'h35 | rkpc_pkg::SCAN_EXT;
			KEY_PAD_STAR: return ctrl ? (8'h37 | rkpc_pkg::SCAN_EXT) : 8'h37;
			7'h5e: return 8'h4e;
			7'h5f: return alt ? 8'h46 : (8'h5d | rkpc_pkg::SCAN_EXT);
			7'h60: return 8'h2a;
			7'h61: return 8'h36;
			7'h62: return 8'h3a;
			7'h63: return 8'h1d;
			7'h64: return 8'h38;
			7'h65: return 8'h38 | rkpc_pkg::SCAN_EXT;
			7'h66: return 8'h5b | rkpc_pkg::SCAN_EXT;
			7'h67: return 8'h5c | rkpc_pkg::SCAN_EXT;
			7'h6b: return alt ? (8'h5d | rkpc_pkg::SCAN_EXT) : 8'h46;
			7'h6c: return alt ? rkpc_pkg::SCAN_NONE : (8'h37 | rkpc_pkg::SCAN_EXT);
			7'h6d: return alt ? (8'h37 | rkpc_pkg::SCAN_EXT) : 8'h45;
			KEY_PAUSE: return ctrl ? (8'h46 | rkpc_pkg::SCAN_EXT) : rkpc_pkg::SCAN_NONE;
			7'h6f: return 8'h58;
			7'h70: return 8'h47 | rkpc_pkg::SCAN_EXT;
			7'h71: return 8'h4f | rkpc_pkg::SCAN_EXT;
			7'h72: return 8'h24 | rkpc_pkg::SCAN_EXT;
			7'h73: return 8'h22 | rkpc_pkg::SCAN_EXT;
			7'h74: return 8'h10 | rkpc_pkg::SCAN_EXT;
			7'h75: return 8'h19 | rkpc_pkg::SCAN_EXT;
			7'h76: return 8'h2e | rkpc_pkg::SCAN_EXT;
			7'h77: return 8'h30 | rkpc_pkg::SCAN_EXT;
			7'h79: return 8'h45;
			default: return rkpc_pkg::SCAN_NONE;
		endcase
	endfunction

	function automatic rkpc_pkg::result_t translate_key(rkpc_pkg::key_t raw,
		rkpc_pkg::qual_t qual, bit alt);
		rkpc_pkg::result_t r;
		rkpc_pkg::key_t    k;
		k = raw;
		r.numlock_write = 1'b0;
		r.numlock_value = 1'b0;
		if (alt && qual[rkpc_pkg::QUAL_PAD]) begin
			r.numlock_write = 1'b1;
			case (raw)
				7'h70: k = 7'h3d;
				7'h4c: k = 7'h3e;
				7'h48: k = 7'h3f;
				7'h4f: k = 7'h2d;
				7'h4e: k = 7'h2f;
				7'h71: k = 7'h1d;
				7'h4d: k = 7'h1e;
				7'h49: k = 7'h1f;
				7'h47: k = 7'h0f;
				7'h46: k = 7'h3c;
				7'h3d, 7'h3e, 7'h3f, 7'h2d, 7'h2e, 7'h2f,
				7'h1d, 7'h1e, 7'h1f, 7'h0f, 7'h3c: r.numlock_value = 1'b1;
				default: r.numlock_write = 1'b0;
			endcase
		end
		r.scan_code = key_to_scan(k, qual[rkpc_pkg::QUAL_CTRL], alt);
		return r;
	endfunction

	task automatic send_key(rkpc_pkg::key_t k, rkpc_pkg::qual_t q);
		int gap;
		key_ch.valid      <= 1'b1;
		key_ch.raw_key    <= k;
		key_ch.qualifiers <= q;
		do @(posedge clk); while (!key_ch.ready);
		scan_expected.push_back(translate_key(k, q, alt_mode));
		gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			key_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		key_ch.valid <= 1'b0;
		while (scan_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(bit m);
		wait_drained();
		mode_we    <= 1'b1;
		mode_wdata <= m;
		@(posedge clk);
		mode_we  <= 1'b0;
		alt_mode = m;
	endtask

	initial begin : scan_sink
		int                 stall;
		rkpc_pkg::result_t  want;
		scan_ch.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				scan_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			scan_ch.ready <= 1'b1;
			do @(posedge clk); while (!scan_ch.valid);
			if (scan_expected.size() == 0) begin
				$error("scan code word 0x%02h arrived with nothing expected",
					scan_ch.scan_code);
				mismatch_count++;
			end else begin
				want = scan_expected.pop_front();
				if (scan_ch.scan_code !== want.scan_code) begin
					$error("scan_code: expected 0x%02h, actual 0x%02h",
						want.scan_code, scan_ch.scan_code);
					mismatch_count++;
				end
				if (scan_ch.numlock_write !== want.numlock_write) begin
					$error("numlock_write: expected %0b, actual %0b",
						want.numlock_write, scan_ch.numlock_write);
					mismatch_count++;
				end
				if (scan_ch.numlock_value !== want.numlock_value) begin
					$error("numlock_value: expected %0b, actual %0b",
						want.numlock_value, scan_ch.numlock_value);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_field_extremes();
		write_mode(1'b0);
		send_key(7'h00, 2'b00);
		send_key(7'h7f, 2'b11);
		send_key(7'h00, 2'b11);
		send_key(7'h7f, 2'b00);
	endtask

	task automatic test_standard_special_keys();
		send_key(7'h0e, 2'b00);
		send_key(7'h68, 2'b10);
		send_key(KEY_PAUSE, 2'b00);
		send_key(KEY_PAUSE, 2'b10);
		send_key(KEY_PAD_STAR, 2'b00);
		send_key(KEY_PAD_STAR, 2'b10);
		send_key(7'h5f, 2'b00);
		send_key(7'h6b, 2'b00);
		send_key(7'h6c, 2'b00);
		send_key(7'h6d, 2'b00);
		// The keypad qualifier has no effect in the standard mode.
		send_key(7'h70, 2'b01);
	endtask

	task automatic test_alternate_keypad();
		write_mode(1'b1);
		send_key(7'h70, 2'b01);
		send_key(7'h3d, 2'b01);
		send_key(KEY_PAD_FIVE, 2'b01);
		send_key(7'h46, 2'b11);
		send_key(7'h45, 2'b01);
		send_key(7'h5f, 2'b00);
		send_key(7'h6c, 2'b10);
		send_key(7'h6d, 2'b00);
	endtask

	task automatic test_random_words();
		int              phase;
		int              n;
		rkpc_pkg::key_t  k;
		rkpc_pkg::qual_t q;
		for (phase = 0; phase < 4; phase++) begin
			write_mode(phase[0]);
			for (n = 0; n < RANDOM_WORDS / 4; n++) begin
				no_idle = (n >= 60 && n < 100);
				if (n == 140) wait_drained();
				if ($urandom_range(0, 99) < 45) begin
					k = KEYPAD_CODES[$urandom_range(0, 20)];
					q = rkpc_pkg::qual_t'($urandom_range(0, 3));
					q[rkpc_pkg::QUAL_PAD] = ($urandom_range(0, 3) != 0);
				end else begin
					k = rkpc_pkg::key_t'($urandom_range(0, 127));
					q = rkpc_pkg::qual_t'($urandom_range(0, 3));
				end
				send_key(k, q);
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		arst_n           <= 1'b0;
		mode_we          <= 1'b0;
		mode_wdata       <= 1'b0;
		key_ch.valid     <= 1'b0;
		key_ch.raw_key   <= '0;
		key_ch.qualifiers <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_standard_special_keys();
		test_alternate_keypad();
		test_random_words();
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && scan_expected.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
